>>> hdl/sds_pkg.sv
// sds_pkg: shared types and constants for the shared dual stack
// transaction payload structs, operation and status codes, controller states
// no dependencies

package sds_pkg;

   // default number of words in the shared array
   localparam int DEPTH_DEFAULT = 16;

   // operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // stack select codes
   localparam logic STACK_LOW  = 1'b0;
   localparam logic STACK_HIGH = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // request transaction
   typedef struct packed {
      logic               opcode;
      logic               stack_select;
      logic signed [31:0] push_value;
   } req_type;

   // response transaction
   typedef struct packed {
      logic signed [31:0] pop_value;
      status_type         status;
   } rsp_type;

   // controller states
   typedef enum logic {
      S_IDLE,
      S_RESP
   } ctrl_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
   } cmd_type;

endpackage

>>> hdl/sds_ctrl.sv
// sds_ctrl: handshake controller for the shared dual stack
// tracks whether a response is held and tells the datapath when to load
// depends on sds_pkg

module sds_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sds_pkg::cmd_type cmd
);

   sds_pkg::ctrl_state_type state_ff;
   sds_pkg::ctrl_state_type state_in;
   logic                    take;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sds_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and handshake outputs
   always_comb begin
      state_in  = state_ff;
      rsp_valid = 1'b0;
      take      = 1'b0;
      unique case (state_ff)
         sds_pkg::S_IDLE: begin
            take = 1'b1;
         end
         sds_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            // a new transaction may enter as the held one leaves
            take = !rsp_stall;
            if (!rsp_stall) begin
               state_in = sds_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sds_pkg::S_IDLE;
         end
      endcase
      req_stall = !take;
      cmd.load  = take && req_valid;
      if (cmd.load) begin
         state_in = sds_pkg::S_RESP;
      end
   end

endmodule

>>> hdl/sds_dp.sv
// sds_dp: datapath of the shared dual stack
// holds the shared word array, both stack counts and the response registers
// depends on sds_pkg

module sds_dp #(
   parameter int DEPTH = sds_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  sds_pkg::cmd_type cmd,
   input  sds_pkg::req_type req_data,
   output sds_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic signed [31:0]  mem [DEPTH];
   logic [CW-1:0]       low_cnt_ff;
   logic [CW-1:0]       low_cnt_in;
   logic [CW-1:0]       high_cnt_ff;
   logic [CW-1:0]       high_cnt_in;
   logic signed [31:0]  rd_data_ff;
   logic                pop_ok_ff;
   sds_pkg::status_type status_ff;
   sds_pkg::status_type status_in;
   logic [CW:0]         total;
   logic                full;
   logic                low_empty;
   logic                high_empty;
   logic [CW-1:0]       addr_wide;
   logic [AW-1:0]       addr;
   logic                wr_en;
   logic                pop_ok;

   assign total      = {1'b0, low_cnt_ff} + {1'b0, high_cnt_ff};
   assign full       = total >= (CW + 1)'(DEPTH);
   assign low_empty  = low_cnt_ff == '0;
   assign high_empty = high_cnt_ff == '0;

   // address, status and count updates for one transaction
   always_comb begin
      low_cnt_in  = low_cnt_ff;
      high_cnt_in = high_cnt_ff;
      status_in   = sds_pkg::STATUS_OK;
      wr_en       = 1'b0;
      pop_ok      = 1'b0;
      priority if (req_data.opcode == sds_pkg::OP_PUSH) begin
         if (req_data.stack_select == sds_pkg::STACK_LOW) begin
            addr_wide = low_cnt_ff;
         end else begin
            addr_wide = CW'(DEPTH - 1) - high_cnt_ff;
         end
         if (full) begin
            status_in = sds_pkg::STATUS_FULL;
         end else begin
            wr_en = cmd.load;
            if (req_data.stack_select == sds_pkg::STACK_LOW) begin
               low_cnt_in = low_cnt_ff + 1'b1;
            end else begin
               high_cnt_in = high_cnt_ff + 1'b1;
            end
         end
      end else if (req_data.stack_select == sds_pkg::STACK_LOW) begin
         addr_wide = low_cnt_ff - 1'b1;
         if (low_empty) begin
            status_in = sds_pkg::STATUS_EMPTY;
         end else begin
            pop_ok     = 1'b1;
            low_cnt_in = low_cnt_ff - 1'b1;
         end
      end else begin
         addr_wide = CW'(DEPTH) - high_cnt_ff;
         if (high_empty) begin
            status_in = sds_pkg::STATUS_EMPTY;
         end else begin
            pop_ok      = 1'b1;
            high_cnt_in = high_cnt_ff - 1'b1;
         end
      end
      addr = addr_wide[AW-1:0];
   end

   // stack counts
   always_ff @(posedge clock) begin
      if (reset) begin
         low_cnt_ff  <= '0;
         high_cnt_ff <= '0;
      end else if (cmd.load) begin
         low_cnt_ff  <= low_cnt_in;
         high_cnt_ff <= high_cnt_in;
      end
   end

   // shared word array, single port with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= req_data.push_value;
      end
      if (cmd.load) begin
         rd_data_ff <= mem[addr];
      end
   end

   // response registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok;
      end
   end

   assign rsp_data.pop_value = pop_ok_ff ? rd_data_ff : 32'sd0;
   assign rsp_data.status    = status_ff;

endmodule

>>> hdl/shared_dual_stack.sv
// shared_dual_stack: top level of two stacks sharing one word array
// joins the handshake controller and the datapath
// depends on sds_pkg, sds_ctrl, sds_dp

// Two LIFO stacks live in one array of DEPTH 32-bit words: the low stack grows
// up from entry 0 and the high stack grows down from entry DEPTH-1. Each
// request transaction is a push or a pop on one stack and gives exactly one
// response transaction: a push is refused with status full once the stacks
// have met, a pop on an empty stack returns status empty, and pop_value is zero
// unless a pop succeeds. The response appears in the cycle after the request is
// taken; the block then holds it and takes the next request in the cycle the
// response leaves, so with no stall on the response side it runs one
// transaction per cycle. That figure is set by the single-port array, which is
// read or written once per transaction with a registered read. The array needs
// no clearing after reset; only the two stack counts are reset.

module shared_dual_stack #(
   parameter int DEPTH = sds_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sds_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sds_pkg::rsp_type rsp_data
);

   sds_pkg::cmd_type cmd;

   // handshake controller
   sds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // stack datapath
   sds_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

>>> bench/shared_dual_stack_tb.sv
// shared_dual_stack_tb: self-checking testbench for the shared dual stack
// a scoreboard class predicts every response, plain tasks drive the request side
// depends on sds_pkg and shared_dual_stack
`timescale 1ns / 100ps

module shared_dual_stack_tb;

   localparam int DEPTH        = sds_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1000;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 120;

   // scoreboard: mirror of both stacks plus the queue of expected responses
   class stack_scoreboard;
      logic [31:0]      words [DEPTH];
      int unsigned      low_count;
      int unsigned      high_count;
      sds_pkg::rsp_type expected_q [$];
      int               fails;
      int               rsp_index;

      function new();
         low_count  = 0;
         high_count = 0;
         fails      = 0;
         rsp_index  = 0;
      endfunction

      // work out the response of one accepted request and update the mirror
      function void note_request(sds_pkg::req_type r);
         sds_pkg::rsp_type e;
         e.pop_value = '0;
         e.status    = sds_pkg::STATUS_OK;
         if (r.opcode == sds_pkg::OP_PUSH) begin
            if (low_count + high_count >= DEPTH) begin
               e.status = sds_pkg::STATUS_FULL;
            end else if (r.stack_select == sds_pkg::STACK_LOW) begin
               words[low_count] = r.push_value;
               low_count++;
            end else begin
               words[DEPTH - 1 - high_count] = r.push_value;
               high_count++;
            end
         end else if (r.stack_select == sds_pkg::STACK_LOW) begin
            if (low_count == 0) begin
               e.status = sds_pkg::STATUS_EMPTY;
            end else begin
               low_count--;
               e.pop_value = words[low_count];
            end
         end else begin
            if (high_count == 0) begin
               e.status = sds_pkg::STATUS_EMPTY;
            end else begin
               e.pop_value = words[DEPTH - high_count];
               high_count--;
            end
         end
         expected_q.push_back(e);
      endfunction

      // compare one accepted response with the oldest expectation
      function void check_response(sds_pkg::rsp_type got);
         sds_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            fails++;
            if (fails <= 10)
               $display("response %0d arrived with nothing expected: pop_value %h status %0d",
                        rsp_index, got.pop_value, got.status);
         end else begin
            e = expected_q.pop_front();
            if (got.pop_value !== e.pop_value || got.status !== e.status) begin
               fails++;
               if (fails <= 10)
                  $display("response %0d mismatch: expected pop_value %h status %0d, got %h %0d",
                           rsp_index, e.pop_value, e.status, got.pop_value, got.status);
            end
         end
         rsp_index++;
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_valid  = 1'b0;
   logic             req_stall;
   sds_pkg::req_type req_data   = '0;
   logic             rsp_valid;
   logic             rsp_stall  = 1'b0;
   sds_pkg::rsp_type rsp_data;

   stack_scoreboard sb;
   bit idle_on       = 1'b1;
   int accepted_reqs = 0;
   int idle_cycles   = 0;

   shared_dual_stack #(
      .DEPTH(DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   function automatic sds_pkg::req_type make_req(logic op, logic sel, logic [31:0] value);
      sds_pkg::req_type r;
      r.opcode       = op;
      r.stack_select = sel;
      r.push_value   = value;
      return r;
   endfunction

   // offer one request transaction, with random gaps ahead of it, until taken
   task automatic send_request(input sds_pkg::req_type r);
      while (idle_on && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(r);
      accepted_reqs++;
   endtask

   // response side stall: random, calm stretch, and one long hold-off
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!hold_done && accepted_reqs >= 250) begin
            rsp_stall <= 1'b1;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < 21);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_response(rsp_data);
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (!reset && ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("shared_dual_stack regression: fail");
         $finish;
      end
   end

   // main sequence
   initial begin
      int push_pct;
      int low_pct;
      sds_pkg::req_type r;
      sb       = new();
      push_pct = 50;
      low_pct  = 50;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: pops on empty stacks, extreme words, then fill until both pushes are refused
      send_request(make_req(sds_pkg::OP_POP, sds_pkg::STACK_LOW, 32'h0000_0000));
      send_request(make_req(sds_pkg::OP_POP, sds_pkg::STACK_HIGH, 32'hffff_ffff));
      send_request(make_req(sds_pkg::OP_PUSH, sds_pkg::STACK_LOW, 32'h7fff_ffff));
      send_request(make_req(sds_pkg::OP_PUSH, sds_pkg::STACK_HIGH, 32'h8000_0000));
      send_request(make_req(sds_pkg::OP_POP, sds_pkg::STACK_HIGH, 32'h1234_5678));
      send_request(make_req(sds_pkg::OP_POP, sds_pkg::STACK_LOW, 32'h0000_0000));
      for (int i = 0; i < DEPTH / 2; i++) begin
         case (i % 4)
            0: begin
               send_request(make_req(sds_pkg::OP_PUSH, sds_pkg::STACK_LOW, 32'hffff_ffff));
               send_request(make_req(sds_pkg::OP_PUSH, sds_pkg::STACK_HIGH, 32'h0000_0000));
            end
            1: begin
               send_request(make_req(sds_pkg::OP_PUSH, sds_pkg::STACK_LOW, 32'h5555_5555));
               send_request(make_req(sds_pkg::OP_PUSH, sds_pkg::STACK_HIGH, 32'haaaa_aaaa));
            end
            default: begin
               send_request(make_req(sds_pkg::OP_PUSH, sds_pkg::STACK_LOW, $urandom));
               send_request(make_req(sds_pkg::OP_PUSH, sds_pkg::STACK_HIGH, $urandom));
            end
         endcase
      end
      send_request(make_req(sds_pkg::OP_PUSH, sds_pkg::STACK_LOW, 32'h0bad_f00d));
      send_request(make_req(sds_pkg::OP_PUSH, sds_pkg::STACK_HIGH, 32'hdead_beef));

      // random: push and stack bias change every fifty items so both stacks fill and drain
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(4))
               0: push_pct = 90;
               1: push_pct = 65;
               2: push_pct = 50;
               3: push_pct = 35;
               default: push_pct = 10;
            endcase
            low_pct = $urandom_range(100);
         end
         idle_on = !(n >= 400 && n < 600);
         // sender holds off until every outstanding response is back
         if (n == 700) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.expected_q.size() != 0) @(posedge clock);
         end
         r.opcode       = ($urandom_range(99) < push_pct) ? sds_pkg::OP_PUSH
                                                          : sds_pkg::OP_POP;
         r.stack_select = ($urandom_range(99) < low_pct) ? sds_pkg::STACK_LOW
                                                         : sds_pkg::STACK_HIGH;
         r.push_value   = $urandom;
         send_request(r);
      end
      req_valid <= 1'b0;

      // drain
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.fails == 0 && sb.expected_q.size() == 0) begin
         $display("shared_dual_stack regression: pass");
      end else begin
         $display("shared_dual_stack regression: fail");
      end
      $finish;
   end

endmodule

>>> shared_dual_stack.f
hdl/sds_pkg.sv
hdl/sds_ctrl.sv
hdl/sds_dp.sv
hdl/shared_dual_stack.sv
bench/shared_dual_stack_tb.sv
